FILE: rtl/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg: shared definitions for the signed decimal formatter
// Default parameters, ASCII codes and the sequencer state type.
// ----------------------------------------------------------------------------
package sdf_pkg;

    // Width of the input port; only the low VALUE_BITS bits are used.
    localparam int IN_W = 64;

    // Default parameter values.
    localparam int VALUE_BITS_DEF = 64;
    localparam int MAX_CHARS_DEF  = 20;

    // Character codes.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_SKIP  = 5'b00100,
        ST_SIGN  = 5'b01000,
        ST_DIGIT = 5'b10000
    } state_t;

endpackage

FILE: rtl/signed_decimal_formatter_top.sv
// Sequence: the value is taken in the idle state, converted by bit-serial double
// dabble over its VALUE_BITS magnitude bits, then leading zeros are dropped (at
// most NDIG-1) and the first character is picked; then one character per cycle
// leaves while the output is free.
// One item at a time: a new value is taken once the last character is registered.
// Reset clears the sequencer and the output valid flag; no memory needs clearing.
// ----------------------------------------------------------------------------
// signed_decimal_formatter_top: signed integer to decimal ASCII text
// Converts the magnitude to BCD one bit per cycle, then streams the sign and
// the significant digits, most significant first, with last on the final one.
// ----------------------------------------------------------------------------
module signed_decimal_formatter_top #(
    parameter int VALUE_BITS = sdf_pkg::VALUE_BITS_DEF,
    parameter int MAX_CHARS  = sdf_pkg::MAX_CHARS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [sdf_pkg::IN_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              char_code,
    output logic                    last
);
    import sdf_pkg::*;

    // Decimal digits needed for the largest magnitude, and the clamped cap.
    localparam int NDIG   = (VALUE_BITS * 3) / 10 + 1;
    localparam int CAP    = (MAX_CHARS < 1) ? 1 : ((MAX_CHARS > 40) ? 40 : MAX_CHARS);
    localparam int BCNT_W = $clog2(VALUE_BITS);
    localparam int DCNT_W = $clog2(NDIG + 1);
    localparam int CCNT_W = $clog2(CAP + 1);

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [NDIG*4-1:0]       bcd_reg, bcd_next;
    logic [BCNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [DCNT_W-1:0]       dig_left_reg, dig_left_next;
    logic [CCNT_W-1:0]       chr_left_reg, chr_left_next;
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              char_reg, char_next;
    logic                    last_reg, last_next;

    logic [VALUE_BITS-1:0]   in_bits;
    logic [NDIG*4-1:0]       bcd_adj;
    logic [3:0]              top_digit;
    logic                    out_free;
    logic                    final_char;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

    assign in_bits   = value[VALUE_BITS-1:0];
    assign top_digit = bcd_reg[NDIG*4-1 -: 4];
    assign out_free  = !out_valid_reg || out_ready;

    // Add three to every digit of five or more before the next shift.
    always_comb
    begin
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd_reg[d*4 +: 4] >= 4'd5)
            begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
            end
        end
    end

    // Sequencer and output register.
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_left_next  = dig_left_reg;
        chr_left_next  = chr_left_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        final_char     = 1'b0;

        // The waiting character leaves on its transfer.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next      = in_bits[VALUE_BITS-1];
                    mag_next      = in_bits[VALUE_BITS-1] ?
                                    VALUE_BITS'(~in_bits + 1'b1) : in_bits;
                    bcd_next      = '0;
                    bit_cnt_next  = BCNT_W'(VALUE_BITS - 1);
                    dig_left_next = DCNT_W'(NDIG);
                    chr_left_next = CCNT_W'(CAP);
                    state_next    = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[NDIG*4-2:0], mag_reg[VALUE_BITS-1]};
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros, but keep at least one digit.
                if (top_digit == 4'd0 && dig_left_reg > DCNT_W'(1))
                begin
                    bcd_next      = {bcd_reg[NDIG*4-5:0], 4'd0};
                    dig_left_next = dig_left_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    final_char     = (chr_left_reg == CCNT_W'(1));
                    char_next      = CHAR_MINUS;
                    last_next      = final_char;
                    out_valid_next = 1'b1;
                    chr_left_next  = chr_left_reg - 1'b1;
                    state_next     = final_char ? ST_IDLE : ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_free)
                begin
                    final_char     = (chr_left_reg == CCNT_W'(1)) ||
                                     (dig_left_reg == DCNT_W'(1));
                    char_next      = CHAR_ZERO + 8'(top_digit);
                    last_next      = final_char;
                    out_valid_next = 1'b1;
                    bcd_next       = {bcd_reg[NDIG*4-5:0], 4'd0};
                    dig_left_next  = dig_left_reg - 1'b1;
                    chr_left_next  = chr_left_reg - 1'b1;
                    if (final_char)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        bcd_reg      <= bcd_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_left_reg <= dig_left_next;
        chr_left_reg <= chr_left_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
    end

endmodule

FILE: verif/signed_decimal_formatter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_formatter_top_tb: self-checking bench for the decimal formatter
// Feeds signed 64-bit values, predicts the ASCII text of each one and checks
// every character transfer, with random gaps, back-pressure and a long stall.
// ----------------------------------------------------------------------------

// One expected character of the formatted text.
typedef struct packed {
    logic [7:0] code;
    logic       is_last;
} text_char_t;

// Predicts the character stream of each accepted value and checks the output.
class decimal_text_board;

    text_char_t expected_chars[$];
    int         errors;
    int         value_bits;
    int         max_chars;

    function new(int vb, int mc);
        value_bits = vb;
        max_chars  = mc;
        errors     = 0;
    endfunction

    // Turn one accepted value into its expected characters.
    function void note_value(logic [63:0] v);
        logic [63:0] mask;
        logic [63:0] sign_mask;
        logic [63:0] bits;
        logic [63:0] mag;
        logic        neg;
        logic [7:0]  rev_digits[20];
        logic [7:0]  text[41];
        text_char_t  item;
        int          nd;
        int          len;
        int          cap;
        int          i;

        mask      = (value_bits >= 64) ? '1 : ((64'd1 << value_bits) - 64'd1);
        sign_mask = 64'd1 << (value_bits - 1);
        bits      = v & mask;
        neg       = (bits & sign_mask) != 64'd0;
        // Unsigned negation keeps the most negative value correct.
        mag       = neg ? ((~bits + 64'd1) & mask) : bits;

        // Digits come out least significant first.
        nd = 0;
        do
        begin
            rev_digits[nd] = sdf_pkg::CHAR_ZERO + 8'(mag % 64'd10);
            nd++;
            mag = mag / 64'd10;
        end while (mag != 64'd0 && nd < 20);

        len = 0;
        if (neg)
        begin
            text[len] = sdf_pkg::CHAR_MINUS;
            len++;
        end
        for (i = nd - 1; i >= 0; i--)
        begin
            text[len] = rev_digits[i];
            len++;
        end

        // Long text is cut to the character budget, last on the final kept one.
        cap = max_chars;
        if (cap < 1) cap = 1;
        if (cap > 40) cap = 40;
        if (len > cap) len = cap;

        for (i = 0; i < len; i++)
        begin
            item.code    = text[i];
            item.is_last = (i == len - 1);
            expected_chars.push_back(item);
        end
    endfunction

    // Compare one output transfer with the oldest expected character.
    function void check_char(logic [7:0] code, logic is_last);
        text_char_t want;

        if (expected_chars.size() == 0)
        begin
            if (errors < 10)
                $display("%0t: unexpected char 0x%02h last %0b, nothing pending",
                         $time, code, is_last);
            errors++;
            return;
        end
        want = expected_chars.pop_front();
        if (code !== want.code || is_last !== want.is_last)
        begin
            if (errors < 10)
                $display("%0t: char mismatch: expected 0x%02h last %0b, got 0x%02h last %0b",
                         $time, want.code, want.is_last, code, is_last);
            errors++;
        end
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction

endclass

module signed_decimal_formatter_top_tb;

    localparam int VB           = sdf_pkg::VALUE_BITS_DEF;
    localparam int MC           = sdf_pkg::MAX_CHARS_DEF;
    localparam int RANDOM_ITEMS = 140;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 150;
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  char_code;
    logic        last;

    decimal_text_board board = new(VB, MC);

    // Shared flags: a stretch without idling, and one long output stall.
    bit steady_flow   = 1'b0;
    bit hold_request  = 1'b0;
    int cycle_count   = 0;

    signed_decimal_formatter_top #(
        .VALUE_BITS(VB),
        .MAX_CHARS (MC)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .char_code(char_code),
        .last     (last)
    );

    // 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("signed_decimal_formatter_top_tb NOT OK");
        $finish;
    end

    // Offer one value and hold it until the input transfer happens.
    task automatic send_value(input logic [63:0] v);
        int gap;

        gap = steady_flow ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_value(v);
        @(negedge clk);
    endtask

    // Random values spread over all text lengths and both signs.
    function automatic logic [63:0] draw_test_value();
        logic [63:0] r;
        logic [63:0] p;
        int          k;

        r = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: ;
            1: r = 64'($urandom_range(0, 999));
            2: r = r >> $urandom_range(1, 63);
            default:
            begin
                p = 64'd1;
                for (k = $urandom_range(0, 18); k > 0; k--) p = p * 64'd10;
                r = p + 64'($urandom_range(0, 2)) - 64'd1;
            end
        endcase
        if ($urandom_range(0, 1) == 1) r = -r;
        return r;
    endfunction

    // Output side: random ready gaps, a stretch of steady flow, one long stall.
    initial
    begin
        int stall;

        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
            begin
                stall = steady_flow ? 0 : $urandom_range(0, 14);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            board.check_char(char_code, last);
            @(negedge clk);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        logic [63:0] corner_values[$];
        int          n;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        value    = '0;

        // Sign, digit-count boundaries and the extremes of the range.
        corner_values = '{
            64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10,
            64'd99, 64'd100, 64'd12345, -64'sd12345,
            64'd999999999999999999, 64'd1000000000000000000,
            -64'sd1000000000000000000,
            64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_FFFF_FFFF,
            64'hFFFF_FFFF_0000_0000
        };

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (corner_values[i]) send_value(corner_values[i]);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady_flow = (n >= 60 && n < 90);
            if (n == 20) hold_request = 1'b1;
            send_value(draw_test_value());
        end
        steady_flow = 1'b0;
        in_valid <= 1'b0;

        // Drain the output, then watch for stray characters.
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("signed_decimal_formatter_top_tb OK");
        else
            $display("signed_decimal_formatter_top_tb NOT OK");
        $finish;
    end

endmodule
